// ===== hdl/tfd_pkg.sv =====
// Shared constants and handshake types for the triple-0xFF deframer.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package tfd_pkg;

  // Result status codes.
  localparam logic [1:0] ST_BYTE      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOCONTENT = 2'd2;
  localparam logic [1:0] ST_TIMEOUT   = 2'd3;

  // Input kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [7:0]  TERM_BYTE     = 8'hFF;
  localparam logic [1:0]  RUN_TO_CLOSE  = 2'd3;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  // Register index of the timeout limit.
  localparam logic REG_TIMEOUT = 1'b0;

  typedef struct packed {
    logic take;       // input word accepted this cycle
    logic load_byte;  // move the stored byte just read into the output register
  } tfd_cmd_t;

  typedef struct packed {
    logic stream;     // the offered word closes a frame that has bytes to emit
    logic out_valid;  // output register holds a result
    logic out_last;   // output register holds the final byte of an event or a single result
  } tfd_sts_t;

endpackage

`default_nettype wire

// ===== hdl/tfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/tfd_ctrl.sv =====
// Sequencing state machine of the deframer: input acceptance and event read-out.
// Depends on tfd_pkg for the command and status structs.
`default_nettype none

module tfd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_ready,
  input  wire tfd_pkg::tfd_sts_t sts,
  output tfd_pkg::tfd_cmd_t      cmd
);

  import tfd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_LD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // A new word may enter while a single result is being taken at the same edge.
  assign in_ready = (state_r == S_IDLE) && (!sts.out_valid || out_ready);

  always_comb begin
    cmd.take      = in_valid && in_ready;
    cmd.load_byte = 1'b0;
    state_nxt     = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.take && sts.stream) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        cmd.load_byte = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = sts.out_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("input ready outside the idle state");

  a_rd_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> !sts.out_valid)
    else $error("memory read issued while the output register is full");

  a_stream_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && sts.stream) |=> (state_r == S_RD))
    else $error("closing word with content did not start the read-out");

  a_load_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD) |=> sts.out_valid)
    else $error("byte load did not fill the output register");
`endif

endmodule

`default_nettype wire

// ===== hdl/tfd_dp.sv =====
// Datapath of the deframer: frame counters, timeout, event length and output register.
// Depends on tfd_pkg; drives the write and read ports of the frame store RAM.
`default_nettype none

module tfd_dp #(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tfd_pkg::tfd_cmd_t              cmd,
  output tfd_pkg::tfd_sts_t                   sts,
  input  wire logic                           in_kind,
  input  wire logic [7:0]                     in_rx_byte,
  input  wire logic [15:0]                    timeout_ticks,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          out_status,
  output logic [7:0]                          out_event_byte,
  output logic                                out_last,
  output logic                                ram_we,
  output logic [$clog2(STORE_DEPTH)-1:0]      ram_waddr,
  output logic [7:0]                          ram_wdata,
  output logic [$clog2(STORE_DEPTH)-1:0]      ram_raddr,
  input  wire logic [7:0]                     ram_rdata
);

  import tfd_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] FILL_MAX = AW'(STORE_DEPTH - 1);

  logic          open_r;
  logic [AW-1:0] fill_r;
  logic [1:0]    run_r;
  logic [15:0]   elapsed_r;
  logic [AW-1:0] len_r;      // bytes before the first zero of the frame
  logic          zseen_r;    // a zero byte has been stored in this frame
  logic [AW-1:0] rd_idx_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic          is_tick;
  logic          is_term;
  logic [1:0]    run_inc;
  logic [15:0]   elapsed_inc;
  logic [AW-1:0] len_base;
  logic          zseen_base;
  logic          closing;
  logic          do_store;
  logic          abort;
  logic          single;
  logic [1:0]    single_code;

  always_comb begin
    is_tick     = (in_kind == KIND_TICK);
    is_term     = (in_rx_byte == TERM_BYTE);
    run_inc     = run_r + 2'd1;
    elapsed_inc = (elapsed_r != ELAPSED_MAX) ? (elapsed_r + 16'd1) : elapsed_r;
    // Length tracking restarts with the byte that opens a frame.
    len_base    = open_r ? len_r : '0;
    zseen_base  = open_r && zseen_r;
    closing     = !is_tick && is_term && (run_inc == RUN_TO_CLOSE);
    do_store    = !is_tick && !is_term && (fill_r < FILL_MAX);
    abort       = is_tick && open_r && (elapsed_inc >= timeout_ticks);
    single      = abort || (closing && ((fill_r == '0) || (len_base == '0)));
    if (abort) begin
      single_code = ST_TIMEOUT;
    end else if (fill_r == '0) begin
      single_code = ST_NOCONTENT;
    end else begin
      single_code = ST_EMPTY;
    end
  end

  assign sts.stream    = closing && (fill_r != '0) && (len_base != '0);
  assign sts.out_valid = out_valid_r;
  assign sts.out_last  = out_last_r;

  assign ram_we    = cmd.take && do_store;
  assign ram_waddr = fill_r;
  assign ram_wdata = in_rx_byte;
  assign ram_raddr = rd_idx_r;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_event_byte = out_byte_r;
  assign out_last       = out_last_r;

  // Frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      fill_r    <= '0;
      run_r     <= '0;
      elapsed_r <= '0;
      len_r     <= '0;
      zseen_r   <= 1'b0;
      rd_idx_r  <= '0;
    end else if (cmd.take) begin
      if (is_tick) begin
        if (open_r) begin
          if (abort) begin
            open_r    <= 1'b0;
            fill_r    <= '0;
            run_r     <= '0;
            elapsed_r <= '0;
          end else begin
            elapsed_r <= elapsed_inc;
          end
        end
      end else if (closing) begin
        // The length is kept: the read-out that follows needs it.
        open_r    <= 1'b0;
        fill_r    <= '0;
        run_r     <= '0;
        elapsed_r <= '0;
        len_r     <= len_base;
        rd_idx_r  <= '0;
      end else begin
        open_r  <= 1'b1;
        run_r   <= is_term ? run_inc : 2'd0;
        // Only non-zero bytes stored before the first zero count towards the event.
        len_r   <= (do_store && (in_rx_byte != 8'd0) && !zseen_base) ?
                   (len_base + AW'(1)) : len_base;
        zseen_r <= zseen_base || (do_store && (in_rx_byte == 8'd0));
        if (do_store) begin
          fill_r <= fill_r + AW'(1);
        end
      end
    end else if (cmd.load_byte) begin
      rd_idx_r <= rd_idx_r + AW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.take && single) || cmd.load_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && single) begin
      out_status_r <= single_code;
      out_byte_r   <= 8'd0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_byte) begin
      out_status_r <= ST_BYTE;
      out_byte_r   <= ram_rdata;
      out_last_r   <= (({1'b0, rd_idx_r} + (AW + 1)'(1)) == {1'b0, len_r});
    end
  end

endmodule

`default_nettype wire

// ===== hdl/triple_ff_terminated_deframer.sv =====
// Top level of the triple-0xFF terminated deframer with its APB register port.
// Depends on tfd_pkg, tfd_ctrl, tfd_dp and tfd_ram.
//
// Usage:
//   Input channel (in_valid/in_ready): each word is a received byte
//   (in_kind = 0, value on in_rx_byte) or one timer tick (in_kind = 1).
//   Result channel (out_valid/out_ready): out_status, out_event_byte, out_last.
//   A word that gives a single result (timeout, empty event, terminator with
//   nothing stored) shows it in the cycle after acceptance. A word that closes a
//   frame with content starts a read-out of the frame store: each event byte
//   passes three steps (RAM address, registered read, output register), and
//   the read-out holds the block until the event's last byte is taken.
//   Other words give no result.
//   A word is taken while a finished result waits only if the receiver takes
//   that result at the same edge; during a read-out no word is taken, and a
//   stalled receiver simply holds the read-out on its current byte.
//   Reset (rst_n low, synchronous) closes any open frame, clears the counters,
//   empties the output register and sets timeout_ticks to 100. The frame store
//   needs no clearing; only bytes written in the current frame are read.
//   Register 0 at address 0: timeout_ticks[15:0]; write it only while idle.
`default_nettype none

module triple_ff_terminated_deframer #(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_event_byte,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import tfd_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  tfd_cmd_t cmd;
  tfd_sts_t sts;

  logic [15:0]   timeout_r;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT)) begin
      timeout_r <= pwdata[15:0];
    end
  end

  tfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tfd_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_rx_byte     (in_rx_byte),
    .timeout_ticks  (timeout_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_event_byte (out_event_byte),
    .out_last       (out_last),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  tfd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== tb/tb_triple_ff_terminated_deframer.sv =====
// Self-checking testbench for the triple-0xFF terminated deframer.
// Depends only on tfd_pkg and triple_ff_terminated_deframer; it keeps its own
// model of the frame state and compares every result word against it.
`timescale 1ns / 100ps

module tb_triple_ff_terminated_deframer;
  import tfd_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] ADDR_TIMEOUT = {REG_TIMEOUT, 2'b00};
  // First address past the register map; writes there must have no effect.
  localparam logic [2:0] ADDR_SPARE = 3'd4;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] event_byte;
    logic       last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = KIND_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_event_byte;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Model state of the deframer.
  logic [15:0] lim_ticks = TIMEOUT_RESET;
  logic [7:0]  frame_buf [STORE_DEPTH];
  int          fill = 0;
  int          ff_count = 0;
  logic [15:0] ticks_seen = 16'd0;
  bit          in_frame = 1'b0;

  result_t     event_q[$];
  int          in_gap_pct = 0;
  int          out_stall_pct = 0;
  int          words_used = 0;
  int          n_results = 0;
  int          n_events = 0;
  int          n_timeouts = 0;
  int          err_count = 0;
  int          cycles = 0;

  triple_ff_terminated_deframer #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_event_byte(out_event_byte),
    .out_last      (out_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped by the cycle limit with %0d results outstanding",
               event_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  function void flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endfunction

  function void shut_frame();
    in_frame = 1'b0;
    fill = 0;
    ff_count = 0;
    ticks_seen = 16'd0;
  endfunction

  function void push_single(input logic [1:0] st);
    event_q.push_back('{status: st, event_byte: 8'h00, last: 1'b1});
    if (st == ST_TIMEOUT) n_timeouts++;
  endfunction

  // Advances the model by one accepted word and queues the results it causes.
  function void deframe_word(input logic kind, input logic [7:0] b);
    int n;
    if (kind == KIND_TICK) begin
      if (!in_frame) return;
      words_used++;
      if (ticks_seen < ELAPSED_MAX) ticks_seen++;
      if (ticks_seen >= lim_ticks) begin
        shut_frame();
        push_single(ST_TIMEOUT);
      end
      return;
    end
    words_used++;
    if (!in_frame) begin
      shut_frame();
      in_frame = 1'b1;
    end
    if (b != TERM_BYTE) begin
      ff_count = 0;
      if (fill < STORE_DEPTH - 1) begin
        frame_buf[fill] = b;
        fill++;
      end
      return;
    end
    ff_count++;
    if (ff_count < int'(RUN_TO_CLOSE)) return;
    if (fill == 0) begin
      push_single(ST_NOCONTENT);
    end else begin
      // The event ends at the first zero byte held.
      n = 0;
      while (n < fill && frame_buf[n] != 8'h00) n++;
      if (n == 0) begin
        push_single(ST_EMPTY);
      end else begin
        n_events++;
        for (int i = 0; i < n; i++) begin
          event_q.push_back('{status: ST_BYTE, event_byte: frame_buf[i],
                              last: (i == n - 1)});
        end
      end
    end
    shut_frame();
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{status: out_status, event_byte: out_event_byte, last: out_last};
        if (event_q.size() == 0) begin
          flag_error($sformatf("unexpected result: status %0d byte %02h last %0b",
                               got.status, got.event_byte, got.last));
        end else begin
          want = event_q.pop_front();
          n_results++;
          if (got !== want) begin
            flag_error($sformatf(
              "result mismatch: expected status %0d byte %02h last %0b, got %0d %02h %0b",
              want.status, want.event_byte, want.last,
              got.status, got.event_byte, got.last));
          end
        end
      end
      if (in_valid && in_ready) deframe_word(in_kind, in_rx_byte);
    end
  end

  // Offers one word, with a random gap in front of it, and waits for acceptance.
  task send_word(input logic kind, input logic [7:0] b);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task send_term();
    repeat (3) send_word(KIND_BYTE, TERM_BYTE);
  endtask

  // Register write followed by a read-back, issued only once the block is idle.
  task cfg_write(input logic [2:0] addr, input logic [31:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (event_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_TIMEOUT) lim_ticks = data[15:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_TIMEOUT && prdata[15:0] !== lim_ticks) begin
      flag_error($sformatf("timeout register read back %04h, expected %04h",
                           prdata[15:0], lim_ticks));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task test_directed_frames();
    in_gap_pct = 8;
    out_stall_pct = 63;
    send_word(KIND_TICK, 8'h5A);  // no frame open, so nothing happens
    send_term();
    send_word(KIND_BYTE, 8'h00);
    send_word(KIND_BYTE, 8'h41);
    send_term();
    send_word(KIND_BYTE, 8'h01);
    send_word(KIND_BYTE, 8'h80);
    send_word(KIND_BYTE, 8'h7F);
    send_word(KIND_BYTE, 8'hFE);
    // A lone 0xFF inside the content must not count towards the terminator.
    send_word(KIND_BYTE, TERM_BYTE);
    send_word(KIND_BYTE, 8'h55);
    send_term();
  endtask

  task test_timeout_register();
    cfg_write(ADDR_TIMEOUT, 32'h0000_0001);
    send_word(KIND_BYTE, 8'h10);
    send_word(KIND_TICK, 8'hA5);
    cfg_write(ADDR_TIMEOUT, 32'h0000_0000);
    send_word(KIND_BYTE, 8'h20);
    send_word(KIND_TICK, 8'h00);
    // Only the low half of the data word reaches the register.
    cfg_write(ADDR_TIMEOUT, 32'hFFFF_0064);
    cfg_write(ADDR_SPARE, 32'h0000_0001);
    send_word(KIND_BYTE, 8'h30);
    send_word(KIND_TICK, 8'hFF);
    send_word(KIND_TICK, 8'h3C);
    // Lowering the limit inside an open frame takes effect on the next tick.
    cfg_write(ADDR_TIMEOUT, 32'h0000_0003);
    send_word(KIND_TICK, 8'hC3);
    cfg_write(ADDR_TIMEOUT, 32'h0000_FFFF);
  endtask

  task test_random_traffic(input int gap_pct, input int stall_pct,
                           input logic [31:0] limit, input int n_words);
    int start;
    int pick;
    int len;
    int r;
    logic [7:0] b;
    cfg_write(ADDR_TIMEOUT, limit);
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    start = words_used;
    while (words_used - start < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Well-formed frame; a few are long enough to overrun the store.
        len = ($urandom_range(0, 99) < 12) ? $urandom_range(50, 75)
                                           : $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 10) send_word(KIND_TICK, 8'($urandom));
          r = $urandom_range(0, 99);
          if (r < 8) b = 8'h00;
          else if (r < 14) b = TERM_BYTE;
          else b = 8'($urandom_range(0, 254));
          send_word(KIND_BYTE, b);
        end
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(0, 99) < 10) send_word(KIND_TICK, 8'($urandom));
          send_word(KIND_BYTE, TERM_BYTE);
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) send_word(1'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        // Abandoned frame left to the timeout.
        repeat ($urandom_range(1, 5)) send_word(KIND_BYTE, 8'($urandom_range(0, 254)));
        len = (lim_ticks > 16'd40) ? $urandom_range(1, 10) : int'(lim_ticks) + 1;
        repeat (len) send_word(KIND_TICK, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_word(KIND_TICK, 8'($urandom));
        send_term();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_timeout_register();
    test_random_traffic(8, 63, 32'($urandom_range(3, 20)), 160);
    test_random_traffic(63, 8, 32'h0000_FFFF, 160);
    test_random_traffic(0, 0, 32'($urandom_range(20, 60)), 160);
    in_valid <= 1'b0;
    @(posedge clk);
    while (event_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (event_q.size() != 0) flag_error("results still outstanding at the end");
    $display("Checked %0d result words from %0d input words: %0d events, %0d timeouts.",
             n_results, words_used, n_events, n_timeouts);
    $display("Timeout limits from 0 to 65535 were exercised with %0d errors.", err_count);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
